// ----- rtl/core/fwgov_pkg.sv -----
// shared types and constants of the frame time workload governor
// no dependencies; compiled before the interfaces and modules

package fwgov_pkg;

	// q1.16 fixed point: factor and ratio carry 17 bits, one above the point
	localparam int FRAC_BITS   = 16;
	localparam int FACTOR_BITS = FRAC_BITS + 1;
	localparam int STEP_BITS   = 16;

	// one quotient or multiplier bit per cycle
	localparam int SERIAL_STEPS = FACTOR_BITS;
	localparam int CNT_BITS     = $clog2(SERIAL_STEPS);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(SERIAL_STEPS - 1);

	// budgets below this are raised to it
	localparam int BUDGET_FLOOR_US = 1000;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_FRAME_BUDGET   = 3'd0,
		REG_INCREASE_STEP  = 3'd1,
		REG_PRIMARY_MIN    = 3'd2,
		REG_SECONDARY_MIN  = 3'd3,
		REG_SECONDARY_RATIO = 3'd4,
		REG_PRIMARY_START  = 3'd5,
		REG_SECONDARY_START = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MLOAD,
		ST_MUL,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		MODE_HOLD,
		MODE_INC,
		MODE_DEC
	} mode_t;

	// load / step strobes for a serial unit
	typedef struct packed {
		logic load;
		logic step;
	} serial_ctl_t;

endpackage

// ----- rtl/core/fwgov_if.sv -----
// channel interfaces of the frame time workload governor
// depends on fwgov_pkg for the configuration field widths

interface fwgov_frame_if #(parameter int TIME_BITS = 20) ();
	logic                 valid;
	logic                 ready;
	logic [TIME_BITS-1:0] frame_time_us;

	modport source(output valid, output frame_time_us, input ready);
	modport sink(input valid, input frame_time_us, output ready);
endinterface

interface fwgov_result_if #(parameter int COUNT_BITS = 24) ();
	logic                  valid;
	logic                  ready;
	logic [COUNT_BITS-1:0] primary_count;
	logic [COUNT_BITS-1:0] secondary_count;
	logic                  was_over_budget;

	modport source(output valid, output primary_count, output secondary_count,
		output was_over_budget, input ready);
	modport sink(input valid, input primary_count, input secondary_count,
		input was_over_budget, output ready);
endinterface

interface fwgov_cfg_if ();
	logic                                 valid;
	logic                                 ready;
	logic [fwgov_pkg::CFG_INDEX_BITS-1:0] index;
	logic [fwgov_pkg::CFG_DATA_BITS-1:0]  data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/frame_time_workload_governor_top.sv -----
// top level of the frame time workload governor
// depends on fwgov_pkg, fwgov_if, fwgov_div and fwgov_mul

// Usage:
// frame_in takes one measured frame time per transaction; result_out returns
// one transaction per frame with the updated primary and secondary counts and
// a flag that marks the decrease path. cfg writes the seven registers by index
// (0 budget, 1 step, 2 and 3 minima, 4 ratio, 5 and 6 start counts, which also
// load the running counts); cfg is always ready, other indexes are ignored.
// Steps from the frame_in transaction to the result:
//   zero frame time: commit only
//   under budget: the serial multiply steps, then the commit
//   at or over budget: the divider steps, a multiplier load, the multiply
//   steps and the commit, carried out by the bit-serial divider and the shared
//   two-lane multiplier
// One frame is processed at a time; frame_in is ready again the cycle after a
// result is written to the output register, so the next frame is taken while
// that result still waits.
// If the receiver stalls and the next result is done, the block holds it
// internally until the output register frees up.
// Reset loads the register defaults (budget 30000, step 1, minima 50 and 10,
// ratio 6554) and counts 1000 and 100, and clears all handshakes.

module frame_time_workload_governor_top #(
	parameter int COUNT_BITS = 24,
	parameter int TIME_BITS  = 20
) (
	input logic          clk,
	input logic          arst_n,
	fwgov_frame_if.sink   frame_in,
	fwgov_result_if.source result_out,
	fwgov_cfg_if.sink     cfg
);
	import fwgov_pkg::*;

	localparam int SUM_BITS = ((COUNT_BITS > STEP_BITS) ? COUNT_BITS : STEP_BITS) + 1;

	// register file
	logic [TIME_BITS-1:0]   budget_q;
	logic [STEP_BITS-1:0]   step_q;
	logic [COUNT_BITS-1:0]  pmin_q;
	logic [COUNT_BITS-1:0]  smin_q;
	logic [FACTOR_BITS-1:0] ratio_q;

	// running counts
	logic [COUNT_BITS-1:0]  primary_rays_q;
	logic [COUNT_BITS-1:0]  secondary_rays_q;

	// control
	state_t                 state_q, state_d;
	mode_t                  mode_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic                   in_fire;
	logic                   cfg_fire;
	logic                   commit;
	serial_ctl_t            div_ctl, mul_ctl;

	// output register
	logic                   out_valid_q;
	logic [COUNT_BITS-1:0]  out_primary_q;
	logic [COUNT_BITS-1:0]  out_secondary_q;
	logic                   out_over_q;
	logic                   out_free;

	// datapath
	logic [TIME_BITS-1:0]   budget_eff;
	logic                   time_zero;
	logic                   under_budget;
	logic [SUM_BITS-1:0]    inc_sum;
	logic [COUNT_BITS-1:0]  primary_inc;
	logic [FACTOR_BITS-1:0] quotient;
	logic [FACTOR_BITS-1:0] mul_factor;
	logic [COUNT_BITS-1:0]  mul_a;
	logic [COUNT_BITS:0]    prod_a, prod_b;
	logic [COUNT_BITS-1:0]  sat_a, sat_b;
	logic [COUNT_BITS-1:0]  next_primary, next_secondary;

	// ---------------------------------------------------------------- handshakes
	assign in_fire    = frame_in.valid && frame_in.ready;
	assign cfg_fire   = cfg.valid && cfg.ready;
	assign cfg.ready  = 1'b1;
	assign out_free   = !out_valid_q || result_out.ready;

	// ---------------------------------------------------------------- input decode
	assign budget_eff   = (budget_q < TIME_BITS'(BUDGET_FLOOR_US)) ?
		TIME_BITS'(BUDGET_FLOOR_US) : budget_q;
	assign time_zero    = frame_in.frame_time_us == '0;
	assign under_budget = frame_in.frame_time_us < budget_eff;

	// additive increase with saturation at the count maximum
	assign inc_sum     = SUM_BITS'(primary_rays_q) + SUM_BITS'(step_q);
	assign primary_inc = (inc_sum[SUM_BITS-1:COUNT_BITS] != '0) ?
		{COUNT_BITS{1'b1}} : inc_sum[COUNT_BITS-1:0];

	// ---------------------------------------------------------------- serial units
	// divider runs only on the decrease path; its quotient is the scale factor
	fwgov_div #(.TIME_BITS(TIME_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (budget_eff),
		.divisor  (frame_in.frame_time_us),
		.quotient (quotient)
	);

	// multiplier is loaded from idle with the ratio on the increase path,
	// otherwise with the quotient after the divide
	assign mul_factor = (state_q == ST_IDLE) ? ratio_q : quotient;
	assign mul_a      = (state_q == ST_IDLE) ? primary_inc : primary_rays_q;

	fwgov_mul #(.COUNT_BITS(COUNT_BITS)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mul_ctl),
		.factor  (mul_factor),
		.mcand_a (mul_a),
		.mcand_b (secondary_rays_q),
		.prod_a  (prod_a),
		.prod_b  (prod_b)
	);

	// ---------------------------------------------------------------- result select
	assign sat_a = prod_a[COUNT_BITS] ? {COUNT_BITS{1'b1}} : prod_a[COUNT_BITS-1:0];
	assign sat_b = prod_b[COUNT_BITS] ? {COUNT_BITS{1'b1}} : prod_b[COUNT_BITS-1:0];

	always_comb begin
		next_primary   = primary_rays_q;
		next_secondary = secondary_rays_q;
		case (mode_q)
			MODE_INC: begin
				// primary already holds the increased count, lane a its product
				next_secondary = sat_a;
			end
			MODE_DEC: begin
				next_primary   = (sat_a < pmin_q) ? pmin_q : sat_a;
				next_secondary = (sat_b < smin_q) ? smin_q : sat_b;
			end
			default: begin
				next_primary   = primary_rays_q;
				next_secondary = secondary_rays_q;
			end
		endcase
	end

	// ---------------------------------------------------------------- state machine
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (time_zero) begin
						state_d = ST_FIN;
					end else if (under_budget) begin
						state_d = ST_MUL;
					end else begin
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (cnt_q == CNT_LAST) begin
					state_d = ST_MLOAD;
				end
			end
			ST_MLOAD: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				if (cnt_q == CNT_LAST) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		frame_in.ready = 1'b0;
		div_ctl        = '0;
		mul_ctl        = '0;
		commit         = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				frame_in.ready = 1'b1;
				div_ctl.load   = in_fire && !time_zero && !under_budget;
				mul_ctl.load   = in_fire && !time_zero && under_budget;
			end
			ST_DIV: begin
				div_ctl.step = 1'b1;
			end
			ST_MLOAD: begin
				mul_ctl.load = 1'b1;
			end
			ST_MUL: begin
				mul_ctl.step = 1'b1;
			end
			ST_FIN: begin
				commit = out_free;
			end
			default: begin
				commit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			mode_q  <= MODE_HOLD;
		end else begin
			state_q <= state_d;
			// step counter shared by divide and multiply phases
			if ((state_q == ST_DIV || state_q == ST_MUL) && cnt_q != CNT_LAST) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (in_fire) begin
				if (time_zero) begin
					mode_q <= MODE_HOLD;
				end else if (under_budget) begin
					mode_q <= MODE_INC;
				end else begin
					mode_q <= MODE_DEC;
				end
			end
		end
	end

	// ---------------------------------------------------------------- registers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q         <= TIME_BITS'(30000);
			step_q           <= STEP_BITS'(1);
			pmin_q           <= COUNT_BITS'(50);
			smin_q           <= COUNT_BITS'(10);
			ratio_q          <= FACTOR_BITS'(6554);
			primary_rays_q   <= COUNT_BITS'(1000);
			secondary_rays_q <= COUNT_BITS'(100);
		end else begin
			if (cfg_fire) begin
				unique case (cfg_reg_t'(cfg.index))
					REG_FRAME_BUDGET:    budget_q <= cfg.data[TIME_BITS-1:0];
					REG_INCREASE_STEP:   step_q   <= cfg.data[STEP_BITS-1:0];
					REG_PRIMARY_MIN:     pmin_q   <= cfg.data[COUNT_BITS-1:0];
					REG_SECONDARY_MIN:   smin_q   <= cfg.data[COUNT_BITS-1:0];
					REG_SECONDARY_RATIO: ratio_q  <= cfg.data[FACTOR_BITS-1:0];
					REG_PRIMARY_START:   primary_rays_q   <= cfg.data[COUNT_BITS-1:0];
					REG_SECONDARY_START: secondary_rays_q <= cfg.data[COUNT_BITS-1:0];
					default: begin
					end
				endcase
			end else if (in_fire && !time_zero && under_budget) begin
				primary_rays_q <= primary_inc;
			end else if (commit) begin
				primary_rays_q   <= next_primary;
				secondary_rays_q <= next_secondary;
			end
		end
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_primary_q   <= next_primary;
			out_secondary_q <= next_secondary;
			out_over_q      <= mode_q == MODE_DEC;
		end
	end

	assign result_out.valid           = out_valid_q;
	assign result_out.primary_count   = out_primary_q;
	assign result_out.secondary_count = out_secondary_q;
	assign result_out.was_over_budget = out_over_q;

endmodule

// ----- rtl/core/fwgov_div.sv -----
// bit-serial restoring divider: floor(budget * 2^16 / time) for budget <= time
// depends on fwgov_pkg

module fwgov_div #(
	parameter int TIME_BITS = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fwgov_pkg::serial_ctl_t              ctl,
	input  logic [TIME_BITS-1:0]                dividend,
	input  logic [TIME_BITS-1:0]                divisor,
	output logic [fwgov_pkg::FACTOR_BITS-1:0]   quotient
);
	import fwgov_pkg::*;

	logic [TIME_BITS:0]     rem_q;
	logic [TIME_BITS-1:0]   dvs_q;
	logic [FACTOR_BITS-1:0] quo_q;
	logic                   ge;
	logic [TIME_BITS:0]     diff;

	// remainder stays below twice the divisor
	assign ge   = rem_q >= {1'b0, dvs_q};
	assign diff = ge ? (rem_q - {1'b0, dvs_q}) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q <= '0;
		end else if (ctl.load) begin
			quo_q <= '0;
		end else if (ctl.step) begin
			quo_q <= {quo_q[FACTOR_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= {1'b0, dividend};
			dvs_q <= divisor;
		end else if (ctl.step) begin
			rem_q <= {diff[TIME_BITS-1:0], 1'b0};
		end
	end

	assign quotient = quo_q;

endmodule

// ----- rtl/core/fwgov_mul.sv -----
// two-lane bit-serial shift-add multiplier, one factor bit per cycle, lsb first
// gives (count * factor) >> 16 per lane; depends on fwgov_pkg

module fwgov_mul #(
	parameter int COUNT_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fwgov_pkg::serial_ctl_t            ctl,
	input  logic [fwgov_pkg::FACTOR_BITS-1:0] factor,
	input  logic [COUNT_BITS-1:0]             mcand_a,
	input  logic [COUNT_BITS-1:0]             mcand_b,
	output logic [COUNT_BITS:0]               prod_a,
	output logic [COUNT_BITS:0]               prod_b
);
	import fwgov_pkg::*;

	logic [FACTOR_BITS-1:0] fac_q;
	logic [COUNT_BITS-1:0]  mcand_q [2];
	logic [COUNT_BITS-1:0]  hi_q [2];
	logic                   last_q [2];
	logic [COUNT_BITS:0]    sum [2];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			sum[i] = {1'b0, hi_q[i]} + (fac_q[0] ? {1'b0, mcand_q[i]} : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fac_q <= '0;
		end else if (ctl.load) begin
			fac_q <= factor;
		end else if (ctl.step) begin
			fac_q <= fac_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mcand_q[0] <= mcand_a;
			mcand_q[1] <= mcand_b;
			for (int i = 0; i < 2; i++) begin
				hi_q[i]   <= '0;
				last_q[i] <= 1'b0;
			end
		end else if (ctl.step) begin
			for (int i = 0; i < 2; i++) begin
				hi_q[i]   <= sum[i][COUNT_BITS:1];
				last_q[i] <= sum[i][0];
			end
		end
	end

	// after all factor bits the last bit shifted out is product bit 16
	assign prod_a = {hi_q[0], last_q[0]};
	assign prod_b = {hi_q[1], last_q[1]};

endmodule
